/* src/ajlf_pkg.sv */
`default_nettype none

package ajlf_pkg;

	// Coordinates and limits are 16-bit two's complement.
	localparam int COORD_W = 16;
	typedef logic signed [COORD_W-1:0] coord_t;

	// Configuration port.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_X_LOWER       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_UPPER       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOWER       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_UPPER       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LOWER       = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Z_UPPER       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_X_NARROW_LOW  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_X_NARROW_HIGH = 4'd7;

	// Limit values after reset.
	localparam coord_t RST_X_LOWER       = 16'sd130;
	localparam coord_t RST_X_UPPER       = 16'sd300;
	localparam coord_t RST_Y_LOWER       = -16'sd90;
	localparam coord_t RST_Y_UPPER       = 16'sd160;
	localparam coord_t RST_Z_LOWER       = -16'sd160;
	localparam coord_t RST_Z_UPPER       = 16'sd180;
	localparam coord_t RST_X_NARROW_LOW  = 16'sd200;
	localparam coord_t RST_X_NARROW_HIGH = 16'sd270;

	// Motion constants.
	localparam coord_t HOME_X   = 16'sd220;
	localparam coord_t HOME_Y   = 16'sd80;
	localparam coord_t HOME_Z   = 16'sd0;
	localparam coord_t NARROW_Y = 16'sd16;
	localparam coord_t WIG_Y    = -16'sd45;
	localparam logic signed [7:0] JOG_STEP = 8'sd10;
	localparam logic signed [7:0] WIG_X    = 8'sd50;
	localparam logic signed [7:0] WIG_Z    = 8'sd10;

	// Frame header.
	localparam logic [7:0] HDR0 = 8'hff;
	localparam logic [7:0] HDR1 = 8'hfe;

	// Key codes (ASCII).
	localparam logic [7:0] KEY_W = 8'h77;
	localparam logic [7:0] KEY_S = 8'h73;
	localparam logic [7:0] KEY_A = 8'h61;
	localparam logic [7:0] KEY_D = 8'h64;
	localparam logic [7:0] KEY_Q = 8'h71;
	localparam logic [7:0] KEY_E = 8'h65;
	localparam logic [7:0] KEY_R = 8'h72;
	localparam logic [7:0] KEY_Z = 8'h7a;

	// Item mode.
	localparam logic MODE_ABS = 1'b0;

	// Classified command.
	typedef enum logic [2:0] {
		CMD_ABS,
		CMD_JOG,
		CMD_HOME,
		CMD_WIGGLE,
		CMD_RESEND
	} op_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		op_t    op;
		axis_t  axis;
		logic   down;
		coord_t x;
		coord_t y;
		coord_t z;
	} cmd_t;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Wiggle sequence steps after the first frame.
	typedef enum logic [3:0] {
		WS_Y,
		WS_XM,
		WS_X0A,
		WS_XP,
		WS_X0B,
		WS_ZM,
		WS_Z0A,
		WS_ZP,
		WS_Z0B,
		WS_RESTORE
	} wig_step_t;

	typedef struct packed {
		logic pop;
		logic wig_active;
	} back_stat_t;

endpackage

`default_nettype wire

/* src/ajlf_front.sv */
`default_nettype none

module ajlf_front (
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             mode,
	input  wire ajlf_pkg::coord_t pos_x,
	input  wire ajlf_pkg::coord_t pos_y,
	input  wire ajlf_pkg::coord_t pos_z,
	input  wire logic [7:0]       key,
	input  wire ajlf_pkg::q_stat_t q_stat,
	output logic                  push,
	output ajlf_pkg::cmd_t        cmd
);
	import ajlf_pkg::*;

	// An item is taken whenever the queue has room.
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	// Classify the item into a command for the back end.
	always_comb begin
		cmd      = '0;
		cmd.op   = CMD_RESEND;
		cmd.axis = AXIS_X;
		cmd.down = 1'b0;
		cmd.x    = pos_x;
		cmd.y    = pos_y;
		cmd.z    = pos_z;
		if (mode == MODE_ABS) begin
			cmd.op = CMD_ABS;
		end else begin
			unique case (key)
				KEY_W: begin cmd.op = CMD_JOG; cmd.axis = AXIS_Y; end
				KEY_S: begin cmd.op = CMD_JOG; cmd.axis = AXIS_Y; cmd.down = 1'b1; end
				KEY_A: begin cmd.op = CMD_JOG; cmd.axis = AXIS_Z; end
				KEY_D: begin cmd.op = CMD_JOG; cmd.axis = AXIS_Z; cmd.down = 1'b1; end
				KEY_Q: begin cmd.op = CMD_JOG; cmd.axis = AXIS_X; end
				KEY_E: begin cmd.op = CMD_JOG; cmd.axis = AXIS_X; cmd.down = 1'b1; end
				KEY_Z: cmd.op = CMD_HOME;
				KEY_R: cmd.op = CMD_WIGGLE;
				default: cmd.op = CMD_RESEND;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/ajlf_queue.sv */
`default_nettype none

module ajlf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ajlf_pkg::cmd_t cmd_in,
	input  wire logic           pop,
	output ajlf_pkg::cmd_t      head,
	output ajlf_pkg::q_stat_t   q_stat
);
	import ajlf_pkg::*;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head         = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

/* src/ajlf_back.sv */
`default_nettype none

module ajlf_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ajlf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire ajlf_pkg::coord_t               cfg_data,
	input  wire ajlf_pkg::cmd_t                 head,
	input  wire ajlf_pkg::q_stat_t              q_stat,
	output ajlf_pkg::back_stat_t                back_stat,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output ajlf_pkg::coord_t                    frame_x,
	output ajlf_pkg::coord_t                    frame_y,
	output ajlf_pkg::coord_t                    frame_z,
	output logic                                frame_last
);
	import ajlf_pkg::*;

	// Add a small signed offset, saturating at the 16-bit range.
	function automatic coord_t sat_add(input coord_t a, input logic signed [7:0] d);
		logic signed [COORD_W:0] s;
		s = (COORD_W+1)'(a) + (COORD_W+1)'(d);
		if (s[COORD_W] != s[COORD_W-1]) begin
			sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			sat_add = s[COORD_W-1:0];
		end
	endfunction

	// Below the lower limit gives the lower limit, above the upper the upper.
	function automatic coord_t clamp(input coord_t v, input coord_t lo, input coord_t hi);
		if (v < lo) begin
			clamp = lo;
		end else if (v > hi) begin
			clamp = hi;
		end else begin
			clamp = v;
		end
	endfunction

	coord_t    x_lower_q, x_upper_q, y_lower_q, y_upper_q;
	coord_t    z_lower_q, z_upper_q, x_nar_low_q, x_nar_high_q;
	coord_t    cur_x_q, cur_y_q, cur_z_q;
	coord_t    p_x_q, p_y_q, p_z_q;
	logic      wig_active_q;
	wig_step_t step_q;
	logic      out_valid_q;
	coord_t    out_x_q, out_y_q, out_z_q;
	logic      out_last_q;

	logic      can_step, do_step, pop;
	coord_t    nx, ny, nz, cx, cy, cz, cx_w;
	logic      nlast;
	logic signed [7:0] jog_d;

	// Limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lower_q    <= RST_X_LOWER;
			x_upper_q    <= RST_X_UPPER;
			y_lower_q    <= RST_Y_LOWER;
			y_upper_q    <= RST_Y_UPPER;
			z_lower_q    <= RST_Z_LOWER;
			z_upper_q    <= RST_Z_UPPER;
			x_nar_low_q  <= RST_X_NARROW_LOW;
			x_nar_high_q <= RST_X_NARROW_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_LOWER:       x_lower_q    <= cfg_data;
				REG_X_UPPER:       x_upper_q    <= cfg_data;
				REG_Y_LOWER:       y_lower_q    <= cfg_data;
				REG_Y_UPPER:       y_upper_q    <= cfg_data;
				REG_Z_LOWER:       z_lower_q    <= cfg_data;
				REG_Z_UPPER:       z_upper_q    <= cfg_data;
				REG_X_NARROW_LOW:  x_nar_low_q  <= cfg_data;
				REG_X_NARROW_HIGH: x_nar_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// One frame is produced per cycle while the output register can take it.
	assign can_step = !out_valid_q || out_ready;
	assign pop      = can_step && !wig_active_q && !q_stat.empty;
	assign do_step  = can_step && (wig_active_q || !q_stat.empty);

	assign back_stat.pop        = pop;
	assign back_stat.wig_active = wig_active_q;

	// Target of the current frame before clamping.
	always_comb begin
		nx    = cur_x_q;
		ny    = cur_y_q;
		nz    = cur_z_q;
		nlast = 1'b1;
		jog_d = head.down ? -JOG_STEP : JOG_STEP;
		if (wig_active_q) begin
			nlast = 1'b0;
			case (step_q)
				WS_XM:   nx = sat_add(p_x_q, -WIG_X);
				WS_X0A:  nx = p_x_q;
				WS_XP:   nx = sat_add(p_x_q, WIG_X);
				WS_X0B:  nx = p_x_q;
				WS_ZM:   nz = sat_add(p_z_q, -WIG_Z);
				WS_Z0A:  nz = p_z_q;
				WS_ZP:   nz = sat_add(p_z_q, WIG_Z);
				WS_Z0B:  nz = p_z_q;
				WS_RESTORE: begin
					nx    = p_x_q;
					ny    = p_y_q;
					nz    = p_z_q;
					nlast = 1'b1;
				end
				default: ;
			endcase
		end else begin
			case (head.op)
				CMD_ABS: begin
					nx = head.x;
					ny = head.y;
					nz = head.z;
				end
				CMD_JOG: begin
					case (head.axis)
						AXIS_X:  nx = sat_add(cur_x_q, jog_d);
						AXIS_Y:  ny = sat_add(cur_y_q, jog_d);
						default: nz = sat_add(cur_z_q, jog_d);
					endcase
				end
				CMD_HOME: begin
					nx = HOME_X;
					ny = HOME_Y;
					nz = HOME_Z;
				end
				CMD_WIGGLE: begin
					ny    = WIG_Y;
					nlast = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Clamp to the limits, then narrow x while y sits low.
	always_comb begin
		cx   = clamp(nx, x_lower_q, x_upper_q);
		cy   = clamp(ny, y_lower_q, y_upper_q);
		cz   = clamp(nz, z_lower_q, z_upper_q);
		cx_w = (cy < NARROW_Y) ? clamp(cx, x_nar_low_q, x_nar_high_q) : cx;
	end

	// Arm state and wiggle sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= HOME_X;
			cur_y_q      <= HOME_Y;
			cur_z_q      <= HOME_Z;
			wig_active_q <= 1'b0;
			step_q       <= WS_Y;
			out_valid_q  <= 1'b0;
		end else begin
			if (do_step) begin
				cur_x_q <= cx_w;
				cur_y_q <= cy;
				cur_z_q <= cz;
			end
			if (pop && head.op == CMD_WIGGLE) begin
				wig_active_q <= 1'b1;
				step_q       <= WS_XM;
			end else if (wig_active_q && do_step) begin
				if (step_q == WS_RESTORE) begin
					wig_active_q <= 1'b0;
				end else begin
					step_q <= wig_step_t'(step_q + 1'b1);
				end
			end
			if (do_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Saved start position and output frame register.
	always_ff @(posedge clk) begin
		if (pop && head.op == CMD_WIGGLE) begin
			p_x_q <= cur_x_q;
			p_y_q <= cur_y_q;
			p_z_q <= cur_z_q;
		end
		if (do_step) begin
			out_x_q    <= cx_w;
			out_y_q    <= cy;
			out_z_q    <= cz;
			out_last_q <= nlast;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_x    = out_x_q;
	assign frame_y    = out_y_q;
	assign frame_z    = out_z_q;
	assign frame_last = out_last_q;

endmodule

`default_nettype wire

/* src/arm_jog_limit_framer.sv */
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   mode, pos_x, pos_y, pos_z, key
// output    out        out_valid / out_ready byte0..byte7, last_frame
// config    in         cfg_we                cfg_index, cfg_data (16 bits)
//
// One frame leaves per cycle while the receiver takes them: position, jog, home and
// resend items give one frame, a wiggle ten, set by the back-end frame sequencer.
// Items pass through a two-entry queue, so the front accepts while frames are made.
// Reset restores the limits and the home position; no clearing pass is needed.
// A stalled output holds the frame register and halts the sequencer.

module arm_jog_limit_framer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           mode,
	input  wire ajlf_pkg::coord_t               pos_x,
	input  wire ajlf_pkg::coord_t               pos_y,
	input  wire ajlf_pkg::coord_t               pos_z,
	input  wire logic [7:0]                     key,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [7:0]                          byte0,
	output logic [7:0]                          byte1,
	output logic [7:0]                          byte2,
	output logic [7:0]                          byte3,
	output logic [7:0]                          byte4,
	output logic [7:0]                          byte5,
	output logic [7:0]                          byte6,
	output logic [7:0]                          byte7,
	output logic                                last_frame,
	input  wire logic                           cfg_we,
	input  wire logic [ajlf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire ajlf_pkg::coord_t               cfg_data
);
	import ajlf_pkg::*;

	q_stat_t    q_stat;
	back_stat_t back_stat;
	cmd_t       push_cmd, head;
	logic       push;
	coord_t     frame_x, frame_y, frame_z;

	// Front end: accept and classify.
	ajlf_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.key      (key),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (push_cmd)
	);

	// Command queue.
	ajlf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (push_cmd),
		.pop    (back_stat.pop),
		.head   (head),
		.q_stat (q_stat)
	);

	// Back end: frame sequencer, clamp and output register.
	ajlf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head       (head),
		.q_stat     (q_stat),
		.back_stat  (back_stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_x    (frame_x),
		.frame_y    (frame_y),
		.frame_z    (frame_z),
		.frame_last (last_frame)
	);

	// Frame bytes, big-endian.
	assign byte0 = HDR0;
	assign byte1 = HDR1;
	assign byte2 = frame_x[15:8];
	assign byte3 = frame_x[7:0];
	assign byte4 = frame_y[15:8];
	assign byte5 = frame_y[7:0];
	assign byte6 = frame_z[15:8];
	assign byte7 = frame_z[7:0];

	// The queue is never reported full and empty at once.
	a_queue_flags : assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// The back end only takes a command from a non-empty queue.
	a_pop_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> !q_stat.empty)
		else $error("pop from an empty queue");

	// No command is taken while a wiggle sequence runs.
	a_no_pop_wiggle : assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.wig_active |-> !back_stat.pop)
		else $error("command taken during a wiggle");

	// The end of a wiggle leaves its final frame in the output register.
	a_wiggle_last : assert property (@(posedge clk) disable iff (!arst_n)
		$fell(back_stat.wig_active) |-> (out_valid && last_frame))
		else $error("wiggle ended without a final frame");

endmodule

`default_nettype wire

/* test/tb_arm_jog_limit_framer.sv */
`timescale 1ns / 1ps

module tb_arm_jog_limit_framer;
	import ajlf_pkg::*;

	// Motion constants, kept apart from the design's own copies.
	localparam int PARK_X       = 220;
	localparam int PARK_Y       = 80;
	localparam int PARK_Z       = 0;
	localparam int JOG_DIST     = 10;
	localparam int SWAY_X       = 50;
	localparam int SWAY_Z       = 10;
	localparam int SWAY_Y       = -45;
	localparam int NARROW_BELOW = 16;

	localparam logic MODE_KEY = 1'b1;
	localparam logic [7:0] KEY_NUL = 8'h00;
	localparam logic [7:0] KEY_DEL = 8'hff;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = 4'd8;

	localparam int RESET_LIMITS [8] = '{130, 300, -90, 160, -160, 180, 200, 270};
	localparam logic [CFG_IDX_W-1:0] LIMIT_REG [8] = '{REG_X_LOWER, REG_X_UPPER,
		REG_Y_LOWER, REG_Y_UPPER, REG_Z_LOWER, REG_Z_UPPER,
		REG_X_NARROW_LOW, REG_X_NARROW_HIGH};
	localparam logic [7:0] KEY_SET [8] = '{KEY_W, KEY_S, KEY_A, KEY_D,
		KEY_Q, KEY_E, KEY_R, KEY_Z};
	localparam int EDGE_VALS [6] = '{-32768, 32767, 15, 16, -1, 0};

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 78;
	localparam int HOLD_OFF     = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE       = 4;
	localparam int MAX_REPORTS  = 200;

	typedef enum {LK_KEEP, LK_RESET, LK_FULL, LK_MODERATE, LK_CROSSED, LK_SCRAMBLED}
		limit_kind_t;

	localparam limit_kind_t PHASE_KIND [PHASES] = '{LK_MODERATE, LK_FULL, LK_MODERATE,
		LK_RESET, LK_CROSSED, LK_SCRAMBLED};

	typedef struct {
		logic       m;
		coord_t     x;
		coord_t     y;
		coord_t     z;
		logic [7:0] k;
	} item_t;

	typedef struct {
		limit_kind_t lk;
		item_t       it;
		bit          pin;
		int          px;
		int          py;
		int          pz;
	} script_row_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   last;
	} frame_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic mode;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	logic [7:0] key;
	logic out_valid;
	logic out_ready;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [7:0] byte2;
	logic [7:0] byte3;
	logic [7:0] byte4;
	logic [7:0] byte5;
	logic [7:0] byte6;
	logic [7:0] byte7;
	logic last_frame;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	coord_t cfg_data;

	// Predicted arm target, limits and the frames still owed by the block.
	int arm_x;
	int arm_y;
	int arm_z;
	int lim [8];
	frame_t frames_due [$];
	script_row_t script [$];

	int err_count;
	bit no_gaps;
	bit squeeze_req;

	arm_jog_limit_framer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte0      (byte0),
		.byte1      (byte1),
		.byte2      (byte2),
		.byte3      (byte3),
		.byte4      (byte4),
		.byte5      (byte5),
		.byte6      (byte6),
		.byte7      (byte7),
		.last_frame (last_frame),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int saturate16(int v);
		if (v < -32768) return -32768;
		if (v > 32767) return 32767;
		return v;
	endfunction

	function automatic int bound(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Clamp the target, write it back and queue the frame that carries it.
	function automatic void emit_frame(bit last);
		frame_t f;
		arm_x = bound(arm_x, lim[REG_X_LOWER], lim[REG_X_UPPER]);
		arm_y = bound(arm_y, lim[REG_Y_LOWER], lim[REG_Y_UPPER]);
		arm_z = bound(arm_z, lim[REG_Z_LOWER], lim[REG_Z_UPPER]);
		if (arm_y < NARROW_BELOW) begin
			arm_x = bound(arm_x, lim[REG_X_NARROW_LOW], lim[REG_X_NARROW_HIGH]);
		end
		f.x = coord_t'(arm_x);
		f.y = coord_t'(arm_y);
		f.z = coord_t'(arm_z);
		f.last = last;
		frames_due.push_back(f);
	endfunction

	// Work out every frame that one accepted item causes.
	function automatic void advance_arm(item_t it);
		int px, py, pz;
		if (it.m == MODE_ABS) begin
			arm_x = it.x;
			arm_y = it.y;
			arm_z = it.z;
		end else begin
			case (it.k)
				KEY_W: arm_y = saturate16(arm_y + JOG_DIST);
				KEY_S: arm_y = saturate16(arm_y - JOG_DIST);
				KEY_A: arm_z = saturate16(arm_z + JOG_DIST);
				KEY_D: arm_z = saturate16(arm_z - JOG_DIST);
				KEY_Q: arm_x = saturate16(arm_x + JOG_DIST);
				KEY_E: arm_x = saturate16(arm_x - JOG_DIST);
				KEY_Z: begin
					arm_x = PARK_X;
					arm_y = PARK_Y;
					arm_z = PARK_Z;
				end
				KEY_R: begin
					// The wiggle works from the start position, not the clamped one.
					px = arm_x;
					py = arm_y;
					pz = arm_z;
					arm_y = SWAY_Y;                   emit_frame(1'b0);
					arm_x = saturate16(px - SWAY_X);  emit_frame(1'b0);
					arm_x = px;                       emit_frame(1'b0);
					arm_x = saturate16(px + SWAY_X);  emit_frame(1'b0);
					arm_x = px;                       emit_frame(1'b0);
					arm_z = saturate16(pz - SWAY_Z);  emit_frame(1'b0);
					arm_z = pz;                       emit_frame(1'b0);
					arm_z = saturate16(pz + SWAY_Z);  emit_frame(1'b0);
					arm_z = pz;                       emit_frame(1'b0);
					arm_x = px;
					arm_y = py;
					arm_z = pz;
				end
				default: ;
			endcase
		end
		emit_frame(1'b1);
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic item_t random_item();
		item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.m = MODE_KEY;
		it.x = coord_t'($urandom);
		it.y = coord_t'($urandom);
		it.z = coord_t'($urandom);
		it.k = 8'($urandom);
		if (r < 28) begin
			it.m = MODE_ABS;
			case ($urandom_range(0, 3))
				0, 1: begin
					it.x = coord_t'(int'($urandom_range(0, 800)) - 400);
					it.y = coord_t'(int'($urandom_range(0, 800)) - 400);
					it.z = coord_t'(int'($urandom_range(0, 800)) - 400);
				end
				2: begin
					it.x = coord_t'(EDGE_VALS[$urandom_range(0, 5)]);
					it.y = coord_t'(EDGE_VALS[$urandom_range(0, 5)]);
					it.z = coord_t'(EDGE_VALS[$urandom_range(0, 5)]);
				end
				default: ;
			endcase
		end else if (r < 88) begin
			it.k = KEY_SET[$urandom_range(0, 7)];
		end
		return it;
	endfunction

	function automatic void add_row(limit_kind_t lk, logic m, int x, int y, int z,
			logic [7:0] k, bit pin = 1'b0, int px = 0, int py = 0, int pz = 0);
		script_row_t row;
		row.lk = lk;
		row.it.m = m;
		row.it.x = coord_t'(x);
		row.it.y = coord_t'(y);
		row.it.z = coord_t'(z);
		row.it.k = k;
		row.pin = pin;
		row.px = px;
		row.py = py;
		row.pz = pz;
		script.push_back(row);
	endfunction

	// Offer one item after a random gap and predict it once it is taken.
	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.m;
		pos_x <= it.x;
		pos_y <= it.y;
		pos_z <= it.z;
		key <= it.k;
		do @(posedge clk); while (!(in_valid && in_ready));
		advance_arm(it);
	endtask

	// Wait until every predicted frame has left the block, then a little longer.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (frames_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx < REG_NONE_FIRST) begin
			lim[idx] = val;
		end
	endtask

	// Load a whole set of limits, then poke an unused index that must be ignored.
	task automatic apply_limits(input limit_kind_t lk);
		int v [8];
		int i;
		case (lk)
			LK_RESET: v = RESET_LIMITS;
			LK_FULL: begin
				for (i = 0; i < 8; i += 2) begin
					v[i] = -32768;
					v[i + 1] = 32767;
				end
			end
			LK_MODERATE: begin
				v[0] = $urandom_range(0, 250);
				v[1] = v[0] + int'($urandom_range(0, 250));
				v[2] = -int'($urandom_range(0, 150));
				v[3] = $urandom_range(0, 200);
				v[4] = -int'($urandom_range(0, 200));
				v[5] = $urandom_range(0, 200);
				v[6] = v[0] + int'($urandom_range(0, 60));
				v[7] = v[6] + int'($urandom_range(0, 120));
			end
			LK_CROSSED: begin
				for (i = 0; i < 8; i += 2) begin
					v[i] = int'($urandom_range(0, 300)) - 100;
					v[i + 1] = v[i] - int'($urandom_range(1, 200));
				end
			end
			default: begin
				for (i = 0; i < 8; i++) begin
					v[i] = int'(coord_t'($urandom));
				end
			end
		endcase
		for (i = 0; i < 8; i++) begin
			write_reg(LIMIT_REG[i], coord_t'(v[i]));
		end
		write_reg(REG_NONE_FIRST + CFG_IDX_W'($urandom_range(0, 7)), coord_t'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Compare each frame taken from the block with the oldest prediction.
	always @(posedge clk) begin : frame_check
		frame_t want;
		logic [7:0] exp_b [8];
		logic [7:0] got_b [8];
		if (arst_n && out_valid && out_ready) begin
			got_b = '{byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7};
			if (frames_due.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS) begin
					$display("%0t: frame expected none got %02h%02h %02h%02h %02h%02h",
						$time, got_b[2], got_b[3], got_b[4], got_b[5], got_b[6], got_b[7]);
				end
			end else begin
				want = frames_due.pop_front();
				exp_b = '{HDR0, HDR1, want.x[15:8], want.x[7:0], want.y[15:8], want.y[7:0],
					want.z[15:8], want.z[7:0]};
				for (int i = 0; i < 8; i++) begin
					if (got_b[i] !== exp_b[i]) begin
						err_count++;
						if (err_count <= MAX_REPORTS) begin
							$display("%0t: byte%0d expected %02h got %02h",
								$time, i, exp_b[i], got_b[i]);
						end
					end
				end
				if (last_frame !== want.last) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$display("%0t: last_frame expected %b got %b",
							$time, want.last, last_frame);
					end
				end
			end
		end
	end

	// The receiver stalls at random, and once holds off long enough to back up the input.
	initial begin : sink
		int r, n, c;
		logic lvl;
		out_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					lvl = 1'b1;
					n = $urandom_range(1, 8);
				end else if (r < 85) begin
					lvl = 1'b0;
					n = $urandom_range(1, 3);
				end else if (r < 93) begin
					lvl = 1'b0;
					n = $urandom_range(10, 40);
				end else begin
					lvl = 1'b1;
					n = $urandom_range(40, 120);
				end
				out_ready <= lvl;
				for (c = 0; c < n && !squeeze_req; c++) @(posedge clk);
			end
		end
	end

	// Stop the run if nothing moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		script_row_t row;
		frame_t f;
		in_valid = 1'b0;
		mode = MODE_ABS;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		key = KEY_NUL;
		cfg_we = 1'b0;
		cfg_index = REG_X_LOWER;
		cfg_data = '0;
		arst_n = 1'b0;
		err_count = 0;
		no_gaps = 1'b0;
		squeeze_req = 1'b0;
		lim = RESET_LIMITS;
		arm_x = PARK_X;
		arm_y = PARK_Y;
		arm_z = PARK_Z;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset limits: resend, extremes, every key, narrow band.
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_NUL, 1'b1, 220, 80, 0);
		add_row(LK_KEEP, MODE_ABS, 32767, 32767, 32767, KEY_NUL, 1'b1, 300, 160, 180);
		add_row(LK_KEEP, MODE_ABS, -32768, -32768, -32768, KEY_DEL, 1'b1, 200, -90, -160);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_Z, 1'b1, 220, 80, 0);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_W);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_S);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_A);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_D);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_Q);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_E);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_R);
		add_row(LK_KEEP, MODE_ABS, 0, 15, 0, KEY_NUL, 1'b1, 200, 15, 0);
		add_row(LK_KEEP, MODE_ABS, 0, 16, 0, KEY_NUL, 1'b1, 130, 16, 0);
		add_row(LK_KEEP, MODE_KEY, -1, -1, -1, KEY_DEL);
		add_row(LK_KEEP, MODE_ABS, 250, 100, 5, KEY_R, 1'b1, 250, 100, 5);
		// Full-range limits, so that jogs and the wiggle saturate at both ends.
		add_row(LK_FULL, MODE_ABS, 32767, 32767, 32767, KEY_NUL, 1'b1, 32767, 32767, 32767);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_Q, 1'b1, 32767, 32767, 32767);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_W);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_R);
		add_row(LK_KEEP, MODE_ABS, -32768, -32768, -32768, KEY_NUL, 1'b1,
			-32768, -32768, -32768);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_E);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_S);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_R);
		// Crossed limits: lower above upper.
		add_row(LK_CROSSED, MODE_ABS, 0, 0, 0, KEY_NUL);
		add_row(LK_KEEP, MODE_KEY, 0, 0, 0, KEY_R);

		foreach (script[i]) begin
			row = script[i];
			if (row.lk != LK_KEEP) begin
				wait_idle();
				apply_limits(row.lk);
			end
			send_item(row.it);
			// A typed-in final frame takes the place of the predicted one.
			if (row.pin) begin
				f = frames_due.pop_back();
				f.x = coord_t'(row.px);
				f.y = coord_t'(row.py);
				f.z = coord_t'(row.pz);
				frames_due.push_back(f);
			end
		end

		// Random items in phases, each under its own set of limits.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			apply_limits(PHASE_KIND[ph]);
			no_gaps = (ph == 2) || (ph == 3);
			if (ph == 3) begin
				squeeze_req = 1'b1;
			end
			repeat (PHASE_ITEMS) send_item(random_item());
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/ajlf_pkg.sv
src/ajlf_front.sv
src/ajlf_queue.sv
src/ajlf_back.sv
src/arm_jog_limit_framer.sv
test/tb_arm_jog_limit_framer.sv
